/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Checks that a condition is followed in the same cycle by a consequence.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/mh2_pkg.sv */
`default_nettype none

package mh2_pkg;

    // Hash constants
    localparam logic [31:0] MURMUR_M   = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT  = 24;
    localparam int unsigned FIN_SHIFT1 = 13;
    localparam int unsigned FIN_SHIFT2 = 15;

    // Register map
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_ADDR = 3'd0;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mix1;
        logic mix2;
        logic tail;
        logic fin;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_full;
        logic in_tail;
        logic in_last;
        logic item_last;
        logic out_free;
    } status_t;

    // Mask of the valid tail bytes, one to three
    function automatic logic [31:0] tail_mask(input logic [1:0] nbytes);
        logic [31:0] mask;
        case (nbytes)
            2'd1:    mask = 32'h0000_00ff;
            2'd2:    mask = 32'h0000_ffff;
            2'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'h0000_0000;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

/* rtl/mh2_if.sv */
`default_nettype none

// Input channel: one message word per beat
interface mh2_in_if;
    logic        valid;
    logic        ready;
    logic        start_msg;
    logic [30:0] msg_length;
    logic [31:0] data_word;
    logic [2:0]  word_bytes;
    logic        last_item;

    modport source (
        output valid, start_msg, msg_length, data_word, word_bytes, last_item,
        input  ready
    );
    modport sink (
        input  valid, start_msg, msg_length, data_word, word_bytes, last_item,
        output ready
    );
endinterface

// Output channel: one finished hash per beat
interface mh2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic        framing_error;

    modport source (
        output valid, hash_value, framing_error,
        input  ready
    );
    modport sink (
        input  valid, hash_value, framing_error,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/murmur2_hash32_stream.sv */
// A full word is accepted, then mixed in two multiply stages (MIX1, MIX2); the
// 1-3 byte tail of a last item is accepted, then mixed in TAIL; a short non-last
// item or an empty last one is only accepted. A last item then adds the finalize
// step, which loads the output register and stalls while the output slot is held.
// A new item is taken only in IDLE. Reset (rst_n low, asynchronous) clears the
// FSM, running hash, error flag, seed register and output valid.
`default_nettype none

`include "assert_macros.svh"

module murmur2_hash32_stream
    import mh2_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    mh2_in_if.sink                     in_ch,
    mh2_out_if.source                  out_ch
);

    logic [31:0] seed_reg;
    cmd_t        cmd;
    status_t     status;
    logic        in_ready;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SEED_ADDR) ? seed_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (psel && penable && pwrite && (paddr == REG_SEED_ADDR))
            seed_reg <= pwdata;
    end

    assign in_ch.ready = in_ready;

    mh2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mh2_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed          (seed_reg),
        .start_msg     (in_ch.start_msg),
        .msg_length    (in_ch.msg_length),
        .data_word     (in_ch.data_word),
        .word_bytes    (in_ch.word_bytes),
        .last_item     (in_ch.last_item),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .hash_value    (out_ch.hash_value),
        .framing_error (out_ch.framing_error)
    );

    // Checks
    `ASSERT_ALWAYS(a_cmd_onehot0, clk, rst_n, $onehot0(cmd))
    `ASSERT_IMPLIES(a_fin_slot_free, clk, rst_n, cmd.fin, status.out_free)
    `ASSERT_IMPLIES(a_out_from_fin, clk, rst_n, $rose(out_ch.valid), $past(cmd.fin))

endmodule

`default_nettype wire

/* rtl/mh2_ctrl.sv */
`default_nettype none

module mh2_ctrl
    import mh2_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MIX1 = 5'b00010,
        ST_MIX2 = 5'b00100,
        ST_TAIL = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Commands
    always_comb
    begin
        cmd.accept = accept;
        cmd.mix1   = (state_reg == ST_MIX1);
        cmd.mix2   = (state_reg == ST_MIX2);
        cmd.tail   = (state_reg == ST_TAIL);
        cmd.fin    = (state_reg == ST_FIN) && status.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.in_full)
                        state_next = ST_MIX1;
                    else if (status.in_last && status.in_tail)
                        state_next = ST_TAIL;
                    else if (status.in_last)
                        state_next = ST_FIN;
                end
            end
            ST_MIX1: state_next = ST_MIX2;
            ST_MIX2: state_next = status.item_last ? ST_FIN : ST_IDLE;
            ST_TAIL: state_next = ST_FIN;
            ST_FIN:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/mh2_datapath.sv */
`default_nettype none

module mh2_datapath
    import mh2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] seed,
    input  wire logic        start_msg,
    input  wire logic [30:0] msg_length,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  word_bytes,
    input  wire logic        last_item,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value,
    output logic             framing_error
);

    logic [31:0] word_reg;
    logic [1:0]  nbytes_reg;
    logic        last_reg;
    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] k_reg;
    logic [31:0] hm_reg;
    logic        err_reg;
    logic        err_next;
    logic [31:0] out_hash_reg;
    logic        out_err_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic        in_full;
    logic        in_tail;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] prod_a;
    logic [31:0] prod_b;

    // Item classification; counts above four act as four
    assign in_full = word_bytes[2];
    assign in_tail = !word_bytes[2] && (word_bytes[1:0] != 2'd0);

    always_comb
    begin
        status.in_full   = in_full;
        status.in_tail   = in_tail;
        status.in_last   = last_item;
        status.item_last = last_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Two multipliers by M, low 32 bits kept
    always_comb
    begin
        op_a = cmd.mix2 ? (k_reg ^ (k_reg >> MIX_SHIFT)) : word_reg;
        if (cmd.tail)
            op_b = h_reg ^ (word_reg & tail_mask(nbytes_reg));
        else if (cmd.fin)
            op_b = h_reg ^ (h_reg >> FIN_SHIFT1);
        else
            op_b = h_reg;
    end

    assign prod_a = op_a * MURMUR_M;
    assign prod_b = op_b * MURMUR_M;

    // Running hash and error flag
    always_comb
    begin
        h_next   = h_reg;
        err_next = err_reg;
        if (cmd.accept)
        begin
            if (start_msg)
            begin
                h_next   = seed ^ {1'b0, msg_length};
                err_next = 1'b0;
            end
            if (!in_full && !last_item)
                err_next = 1'b1;
        end
        else if (cmd.mix2)
            h_next = hm_reg ^ prod_a;
        else if (cmd.tail)
            h_next = prod_b;
    end

    // Output slot: cleared on a taken beat, loaded on finalize
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.fin)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h_reg         <= h_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg   <= data_word;
            nbytes_reg <= word_bytes[1:0];
            last_reg   <= last_item;
        end
        if (cmd.mix1)
        begin
            k_reg  <= prod_a;
            hm_reg <= prod_b;
        end
        if (cmd.fin)
        begin
            out_hash_reg <= prod_b ^ (prod_b >> FIN_SHIFT2);
            out_err_reg  <= err_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hash_value    = out_hash_reg;
    assign framing_error = out_err_reg;

endmodule

`default_nettype wire
